// ===== rtl/core/tebc_pkg.sv =====
// ----------------------------------------------------------------------------
// tebc_pkg
// Shared register codes and item flags for the triangle edge/barycentric block.
// ----------------------------------------------------------------------------
package tebc_pkg;

  localparam int RegIndexBits = 3;

  typedef enum logic [RegIndexBits-1:0] {
    REG_V0X = 3'd0,
    REG_V0Y = 3'd1,
    REG_V1X = 3'd2,
    REG_V1Y = 3'd3,
    REG_V2X = 3'd4,
    REG_V2Y = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic covered;
    logic degen;
    logic ok;      // covered and nonzero area: weights are computed
  } item_flags_t;

  localparam int FlagBits = $bits(item_flags_t);

endpackage

// ===== rtl/core/tebc_front.sv =====
// ----------------------------------------------------------------------------
// tebc_front
// Vertex registers, edge function pipeline and inside/area classification.
// ----------------------------------------------------------------------------
module tebc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tebc_pkg::RegIndexBits-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_BITS-1:0]           pixel_x,
  input  logic [COORD_BITS-1:0]           pixel_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tebc_pkg::item_flags_t           out_flags,
  output logic [2*COORD_BITS+3:0]         out_n0,
  output logic [2*COORD_BITS+3:0]         out_n1,
  output logic [2*COORD_BITS+3:0]         out_n2,
  output logic [2*COORD_BITS+3:0]         out_d
);
  import tebc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int MW = 2*COORD_BITS+4;

  logic [C-1:0] vx [3];
  logic [C-1:0] vy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        vx[k] <= '0;
        vy[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_V0X: vx[0] <= cfg_data;
        REG_V0Y: vy[0] <= cfg_data;
        REG_V1X: vx[1] <= cfg_data;
        REG_V1Y: vy[1] <= cfg_data;
        REG_V2X: vx[2] <= cfg_data;
        REG_V2Y: vy[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] v;
  logic [3:0] adv;

  assign adv[3]    = !v[3] || out_ready;
  assign adv[2]    = !v[2] || adv[3];
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
  end

  logic signed [C:0]     ex [3];
  logic signed [C:0]     ey [3];
  logic signed [C:0]     cx [3];
  logic signed [C:0]     cy [3];
  logic signed [2*C+1:0] pa [3];
  logic signed [2*C+1:0] pb [3];
  logic signed [2*C+2:0] e  [3];

  for (genvar k = 0; k < 3; k++) begin : g_edge
    localparam int B = (k == 2) ? 0 : k + 1;
    always_ff @(posedge clk) begin
      if (adv[0]) begin
        ex[k] <= {vx[B][C-1], vx[B]} - {vx[k][C-1], vx[k]};
        ey[k] <= {vy[B][C-1], vy[B]} - {vy[k][C-1], vy[k]};
        cx[k] <= {pixel_x[C-1], pixel_x} - {vx[k][C-1], vx[k]};
        cy[k] <= {pixel_y[C-1], pixel_y} - {vy[k][C-1], vy[k]};
      end
      if (adv[1]) begin
        pa[k] <= ex[k] * cy[k];
        pb[k] <= ey[k] * cx[k];
      end
      if (adv[2]) e[k] <= pa[k] - pb[k];
    end
  end

  // classify: sum is twice the signed area
  logic signed [2*C+4:0] s;
  logic [MW-1:0]         mag_s;
  logic [MW-1:0]         mag_e [3];
  logic                  all_ge;
  logic                  all_le;
  item_flags_t           flags_next;

  always_comb begin
    s = e[0] + e[1] + e[2];
    mag_s = s[2*C+4] ? MW'(-s) : MW'(s);
    for (int k = 0; k < 3; k++) begin
      mag_e[k] = e[k][2*C+2] ? MW'(-e[k]) : MW'(e[k]);
    end
    all_ge = !e[0][2*C+2] && !e[1][2*C+2] && !e[2][2*C+2];
    all_le = (e[0] <= 0) && (e[1] <= 0) && (e[2] <= 0);
    flags_next.covered = all_ge || all_le;
    flags_next.degen   = (s == 0);
    flags_next.ok      = flags_next.covered && !flags_next.degen;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      out_flags <= flags_next;
      out_n0    <= flags_next.ok ? mag_e[1] : '0;
      out_n1    <= flags_next.ok ? mag_e[2] : '0;
      out_n2    <= flags_next.ok ? mag_e[0] : '0;
      out_d     <= flags_next.ok ? mag_s : MW'(1);
    end
  end

endmodule

// ===== rtl/core/tebc_queue.sv =====
// ----------------------------------------------------------------------------
// tebc_queue
// Short register queue between classification and the divider pipeline.
// ----------------------------------------------------------------------------
module tebc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr)) else $error("queue pointers disagree");

endmodule

// ===== rtl/core/tebc_back.sv =====
// ----------------------------------------------------------------------------
// tebc_back
// Pipelined restoring divider: three weights per item, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tebc_back #(
  parameter int MW = 36,
  parameter int F  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tebc_pkg::item_flags_t in_flags,
  input  logic [MW-1:0]         in_n0,
  input  logic [MW-1:0]         in_n1,
  input  logic [MW-1:0]         in_n2,
  input  logic [MW-1:0]         in_d,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  inside_res,
  output logic                  degenerate,
  output logic [F:0]            weight0,
  output logic [F:0]            weight1,
  output logic [F:0]            weight2
);
  import tebc_pkg::*;

  localparam int QW = F + 2;   // integer bit plus F+1 fraction bits
  localparam int NQ = F + 2;   // first compare plus F+1 shift steps

  logic        v     [NQ];
  logic        adv   [NQ];
  item_flags_t flags [NQ];
  logic [MW-1:0] d   [NQ];
  logic [MW-1:0] r   [NQ][3];
  logic [QW-1:0] q   [NQ][3];

  logic        out_v;
  logic        adv_out;
  item_flags_t out_flags;

  assign adv_out   = !out_v || out_ready;
  assign in_ready  = adv[0];
  assign out_valid = out_v;

  for (genvar s = 0; s < NQ; s++) begin : g_adv
    if (s == NQ-1) begin : g_last
      assign adv[s] = !v[s] || adv_out;
    end else begin : g_mid
      assign adv[s] = !v[s] || adv[s+1];
    end
  end

  logic [MW-1:0] n_in [3];
  assign n_in[0] = in_n0;
  assign n_in[1] = in_n1;
  assign n_in[2] = in_n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NQ; s++) v[s] <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int s = 1; s < NQ; s++) begin
        if (adv[s]) v[s] <= v[s-1];
      end
      if (adv_out) out_v <= v[NQ-1];
    end
  end

  // first step: integer quotient bit (numerator never exceeds divisor)
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      flags[0] <= in_flags;
      d[0]     <= in_d;
      for (int l = 0; l < 3; l++) begin
        r[0][l] <= (n_in[l] >= in_d) ? n_in[l] - in_d : n_in[l];
        q[0][l] <= QW'(n_in[l] >= in_d);
      end
    end
  end

  for (genvar s = 1; s < NQ; s++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [MW:0] rs;
      logic        ge;
      assign rs = {r[s-1][l], 1'b0};
      assign ge = (rs >= {1'b0, d[s-1]});
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          r[s][l] <= ge ? MW'(rs - {1'b0, d[s-1]}) : MW'(rs);
          q[s][l] <= {q[s-1][l][QW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        flags[s] <= flags[s-1];
        d[s]     <= d[s-1];
      end
    end
  end

  // round half up: drop the extra fraction bit after adding one
  logic [QW:0] rnd [3];
  always_comb begin
    for (int l = 0; l < 3; l++) rnd[l] = {1'b0, q[NQ-1][l]} + (QW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_flags <= flags[NQ-1];
      weight0   <= flags[NQ-1].ok ? rnd[0][F+1:1] : '0;
      weight1   <= flags[NQ-1].ok ? rnd[1][F+1:1] : '0;
      weight2   <= flags[NQ-1].ok ? rnd[2][F+1:1] : '0;
    end
  end

  assign inside_res = out_flags.covered;
  assign degenerate = out_flags.degen;

  a_zero_weights: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_flags.ok) |-> (weight0 == '0 && weight1 == '0 && weight2 == '0))
    else $error("weights nonzero for outside or degenerate item");

  a_degen_not_ok: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_flags.degen) |-> !out_flags.ok)
    else $error("degenerate item marked for division");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (weight0 <= (F+1)'(1 << F) && weight1 <= (F+1)'(1 << F)
               && weight2 <= (F+1)'(1 << F)))
    else $error("weight above one");

endmodule

// ===== rtl/core/triangle_edge_barycentric_2d.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_barycentric_2d
// Triangle coverage test and barycentric weights, one sample per clock when not stalled.
// ----------------------------------------------------------------------------
// Write the three vertices through the write port while no sample is in
// flight, then push sample points. The block accepts one sample every clock
// while full is low (pop back-pressure can stall it) and returns one word per
// sample in order: inside flag, zero-area flag and three Q1.16 weights (zero
// when the sample is outside or the area is zero). A sample passes through
// the edge-function pipeline, the 4-entry queue and the restoring divider
// pipeline, which resolves one quotient bit per stage for all three weights
// in parallel.
module triangle_edge_barycentric_2d #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  input  logic                              write_enable,
  input  logic [tebc_pkg::RegIndexBits-1:0] write_index,
  input  logic [COORD_BITS-1:0]             write_data,
  output logic                              empty,
  input  logic                              pop,
  output logic                              inside_res,
  output logic                              degenerate,
  output logic [WEIGHT_FRAC_BITS:0]         weight0,
  output logic [WEIGHT_FRAC_BITS:0]         weight1,
  output logic [WEIGHT_FRAC_BITS:0]         weight2
);
  import tebc_pkg::*;

  localparam int MW = 2*COORD_BITS+4;
  localparam int QD = FlagBits + 4*MW;

  logic          in_ready;
  logic          f_valid;
  logic          f_ready;
  item_flags_t   f_flags;
  logic [MW-1:0] f_n0;
  logic [MW-1:0] f_n1;
  logic [MW-1:0] f_n2;
  logic [MW-1:0] f_d;
  logic          q_valid;
  logic          q_ready;
  logic [QD-1:0] q_data;
  logic          b_valid;

  assign full  = !in_ready;
  assign empty = !b_valid;

  tebc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (write_enable),
    .cfg_index (write_index),
    .cfg_data  (write_data),
    .in_valid  (push),
    .in_ready  (in_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_flags (f_flags),
    .out_n0    (f_n0),
    .out_n1    (f_n1),
    .out_n2    (f_n2),
    .out_d     (f_d)
  );

  tebc_queue #(.WIDTH(QD), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_flags, f_n0, f_n1, f_n2, f_d}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  tebc_back #(.MW(MW), .F(WEIGHT_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_flags   (item_flags_t'(q_data[QD-1 -: FlagBits])),
    .in_n0      (q_data[4*MW-1 -: MW]),
    .in_n1      (q_data[3*MW-1 -: MW]),
    .in_n2      (q_data[2*MW-1 -: MW]),
    .in_d       (q_data[MW-1:0]),
    .out_valid  (b_valid),
    .out_ready  (pop),
    .inside_res (inside_res),
    .degenerate (degenerate),
    .weight0    (weight0),
    .weight1    (weight1),
    .weight2    (weight2)
  );

endmodule
